// ===== rtl/srle_pkg.sv =====
// ---------------------------------------------------------------------------
// srle_pkg
// Types and byte codes shared by the sprite run-length decoder modules.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package srle_pkg;

	localparam logic [7:0] CODE_EOL   = 8'hff;
	localparam logic [7:0] CODE_COUNT = 8'hfe;
	localparam logic [7:0] CODE_SKIP  = 8'hfd;

	localparam logic [10:0] COL_MAX = 11'd2047;
	localparam logic [9:0]  ROW_MAX = 10'd1023;

	localparam logic REG_WIDTH  = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;

	typedef enum logic [2:0] {
		MODE_LINE    = 3'd0,
		MODE_LIT     = 3'd1,
		MODE_RUN     = 3'd2,
		MODE_RUN_VAL = 3'd3,
		MODE_LIT_CNT = 3'd4,
		MODE_LIT_VAL = 3'd5,
		MODE_DONE    = 3'd7
	} mode_t;

	typedef enum logic [1:0] {
		EV_FILL  = 2'd0,
		EV_STRAY = 2'd1,
		EV_DONE  = 2'd2
	} event_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} item_t;

	typedef struct packed {
		event_t      event_res;
		logic [19:0] run_start;
		logic [7:0]  run_length;
		logic [7:0]  colour;
	} result_t;

endpackage

// ===== rtl/srle_in_stage.sv =====
// ---------------------------------------------------------------------------
// srle_in_stage
// Input register: holds one compressed byte until the decoder takes it.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module srle_in_stage
	import srle_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  s_tvalid,
	output logic  s_tready,
	input  item_t s_item,
	input  logic  take,
	output logic  valid_s1,
	output item_t item_s1
);

	assign s_tready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1 <= s_item;
		end
	end

endmodule

// ===== rtl/srle_core.sv =====
// ---------------------------------------------------------------------------
// srle_core
// Parse state and counters; one byte per cycle while take is high, into at most one result.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module srle_core
	import srle_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       take,
	input  item_t      item_s1,
	input  logic [9:0] image_width,
	input  logic [9:0] image_height,
	output logic       res_valid,
	output result_t    res
);

	mode_t       mode_q, mode_d;
	logic [10:0] column_q, column_d;
	logic [9:0]  row_q, row_d;
	logic [19:0] row_base_q, row_base_d;
	logic [7:0]  pending_q, pending_d;

	logic [7:0]  b;
	logic [19:0] here;
	logic [10:0] col_inc1;
	logic [11:0] col_sum;
	logic [10:0] col_incp;
	logic [9:0]  row_inc;
	logic [19:0] base_inc;
	logic        done_after_row;

	assign b        = item_s1.data_byte;
	assign here     = row_base_q + {9'd0, column_q};
	assign col_inc1 = (column_q == COL_MAX) ? COL_MAX : column_q + 11'd1;
	assign col_sum  = {1'b0, column_q} + {4'd0, pending_q};
	assign col_incp = (col_sum > {1'b0, COL_MAX}) ? COL_MAX : col_sum[10:0];
	assign row_inc  = (row_q < ROW_MAX) ? row_q + 10'd1 : row_q;
	assign base_inc = row_base_q + {10'd0, image_width};
	assign done_after_row = (row_inc >= image_height);

	always_comb begin
		mode_d     = mode_q;
		column_d   = column_q;
		row_d      = row_q;
		row_base_d = row_base_q;
		pending_d  = pending_q;
		res_valid  = 1'b0;
		res        = '{event_res: EV_FILL, run_start: 20'd0, run_length: 8'd0, colour: 8'd0};

		unique case (mode_q)
			MODE_LINE: begin
				if (row_q >= image_height) begin
					mode_d    = MODE_DONE;
					res_valid = 1'b1;
					res.event_res = EV_DONE;
				end else if (b == CODE_EOL) begin
					column_d   = 11'd0;
					row_d      = row_inc;
					row_base_d = base_inc;
					mode_d     = done_after_row ? MODE_DONE : MODE_LINE;
					res_valid  = done_after_row;
					res.event_res = EV_DONE;
				end else if (b == CODE_SKIP) begin
					mode_d = MODE_RUN;
				end else begin
					mode_d = MODE_LIT;
				end
			end
			MODE_RUN: begin
				if (b == CODE_EOL) begin
					column_d   = 11'd0;
					row_d      = row_inc;
					row_base_d = base_inc;
					mode_d     = done_after_row ? MODE_DONE : MODE_LINE;
					res_valid  = done_after_row;
					res.event_res = EV_DONE;
				end else begin
					pending_d = b;
					mode_d    = MODE_RUN_VAL;
				end
			end
			MODE_RUN_VAL, MODE_LIT_VAL: begin
				res_valid      = (b != CODE_SKIP) && (pending_q != 8'd0);
				res.event_res  = EV_FILL;
				res.run_start  = here;
				res.run_length = pending_q;
				res.colour     = b;
				column_d       = col_incp;
				mode_d         = (mode_q == MODE_RUN_VAL) ? MODE_RUN : MODE_LIT;
			end
			MODE_LIT: begin
				if (b == CODE_EOL) begin
					column_d   = 11'd0;
					row_d      = row_inc;
					row_base_d = base_inc;
					mode_d     = done_after_row ? MODE_DONE : MODE_LINE;
					res_valid  = done_after_row;
					res.event_res = EV_DONE;
				end else if (column_q == {1'b0, image_width}) begin
					res_valid     = 1'b1;
					res.event_res = EV_STRAY;
					res.run_start = here;
					res.colour    = b;
				end else if (b == CODE_COUNT) begin
					mode_d = MODE_LIT_CNT;
				end else if (b == CODE_SKIP) begin
					column_d = col_inc1;
				end else begin
					res_valid      = 1'b1;
					res.event_res  = EV_FILL;
					res.run_start  = here;
					res.run_length = 8'd1;
					res.colour     = b;
					column_d       = col_inc1;
				end
			end
			MODE_LIT_CNT: begin
				pending_d = b;
				mode_d    = MODE_LIT_VAL;
			end
			default: begin
				mode_d = mode_q;
			end
		endcase

		if (item_s1.last_byte) begin
			mode_d     = MODE_LINE;
			column_d   = 11'd0;
			row_d      = 10'd0;
			row_base_d = 20'd0;
			pending_d  = 8'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= MODE_LINE;
			column_q   <= 11'd0;
			row_q      <= 10'd0;
			row_base_q <= 20'd0;
			pending_q  <= 8'd0;
		end else if (take) begin
			mode_q     <= mode_d;
			column_q   <= column_d;
			row_q      <= row_d;
			row_base_q <= row_base_d;
			pending_q  <= pending_d;
		end
	end

endmodule

// ===== rtl/srle_out_reg.sv =====
// ---------------------------------------------------------------------------
// srle_out_reg
// Result register on the master side; holds a result while the sink stalls.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module srle_out_reg
	import srle_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    load,
	input  logic    res_valid,
	input  result_t res,
	output logic    free,
	output logic    m_tvalid,
	input  logic    m_tready,
	output result_t res_q
);

	assign free = !m_tvalid || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (free) begin
			m_tvalid <= load && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (free && load && res_valid) begin
			res_q <= res;
		end
	end

endmodule

// ===== rtl/sprite_rle_decoder_top.sv =====
// ---------------------------------------------------------------------------
// sprite_rle_decoder_top
// Run-length decoder for compressed sprite rows, one byte per cycle when not stalled.
// ---------------------------------------------------------------------------
// Slave channel s_*: one compressed byte per request in s_tdata, s_tlast on the
// final byte of a sprite; parse state returns to line start after that byte.
// Master channel m_*: at most one result per byte; m_tuser is the event kind
// (fill run, stray byte, image complete), m_tdata the run start address,
// length and colour.
// Configuration: cfg_we with cfg_addr 0 (width) or 1 (height) and cfg_data;
// values above MAX_DIM are clamped. Write only while the block is idle.
// An accepted byte sits in the input register, is decoded by the core and, once
// the output register is free, its result is registered there for the master side.
// Throughput is one byte per cycle while the master side does not stall, with mode,
// column, row and row base all updated together for each byte.
// A byte with no result simply leaves no request on the master side.
// Reset clears the parse state and the valid bits of both registers, so the pipeline empties; width and
// height return to 320 and 200. When m_tready is low the held result stays
// and the input register fills, then s_tready drops until the sink takes it.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module sprite_rle_decoder_top
	import srle_pkg::*;
#(
	parameter int MAX_DIM = 1023
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic        s_tlast,   // last_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // [19:0] run_start, [27:20] run_length, [35:28] colour
	output logic [1:0]  m_tuser,   // [1:0] event_res
	input  logic        cfg_we,
	input  logic        cfg_addr,
	input  logic [9:0]  cfg_data
);

	localparam logic [11:0] DIM_LIMIT = 12'(MAX_DIM);
	localparam logic [9:0]  WIDTH_RST = 10'd320;
	localparam logic [9:0]  HEIGHT_RST = 10'd200;

	function automatic logic [9:0] clamp_dim(input logic [9:0] v);
		return ({2'b00, v} > DIM_LIMIT) ? DIM_LIMIT[9:0] : v;
	endfunction

	logic [9:0] image_width_q;
	logic [9:0] image_height_q;
	item_t      s_item;
	logic       valid_s1;
	item_t      item_s1;
	logic       free;
	logic       take;
	logic       res_valid;
	result_t    res;
	result_t    res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q  <= clamp_dim(WIDTH_RST);
			image_height_q <= clamp_dim(HEIGHT_RST);
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_WIDTH:  image_width_q  <= clamp_dim(cfg_data);
				REG_HEIGHT: image_height_q <= clamp_dim(cfg_data);
				default:    image_width_q  <= image_width_q;
			endcase
		end
	end

	assign take = valid_s1 && free;
	assign s_item = '{data_byte: s_tdata, last_byte: s_tlast};

	srle_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_item   (s_item),
		.take     (take),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	srle_core u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.take         (take),
		.item_s1      (item_s1),
		.image_width  (image_width_q),
		.image_height (image_height_q),
		.res_valid    (res_valid),
		.res          (res)
	);

	srle_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (take),
		.res_valid (res_valid),
		.res       (res),
		.free      (free),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.res_q     (res_q)
	);

	assign m_tdata = {4'd0, res_q.colour, res_q.run_length, res_q.run_start};
	assign m_tuser = res_q.event_res;

endmodule

// ===== rtl/srle_checker.sv =====
// ---------------------------------------------------------------------------
// srle_checker
// Port-level checks of the sprite decoder result stream.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module srle_checker
	import srle_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [39:0] m_tdata,
	input logic [1:0]  m_tuser
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result dropped or changed while stalled");

	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tuser == EV_FILL || m_tuser == EV_STRAY || m_tuser == EV_DONE))
		else $error("undefined event kind");

	a_done: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == EV_DONE |-> m_tdata == 40'd0)
		else $error("image complete carries payload");

	a_len: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ((m_tuser == EV_FILL) == (m_tdata[27:20] != 8'd0)))
		else $error("run length does not match event kind");

endmodule

bind sprite_rle_decoder_top srle_checker u_srle_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
